[design/otimer_pkg.sv]
package otimer_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [31:0] WINDOW_RESET = 32'd3600000;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CANCEL  = 3'd1;
   localparam logic [2:0] OP_REFRESH = 3'd2;
   localparam logic [2:0] OP_RESET   = 3'd3;
   localparam logic [2:0] OP_POLL    = 3'd4;
   localparam logic [2:0] OP_QUERY   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INACTIVE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NONE_DUE = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] now_ms;
      logic [3:0]  slot_id;
      logic [31:0] period_ms;
      logic        repeat_mode;
      logic        restart_now;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  result_slot;
      logic [63:0] delay_ms;
      logic        front_notify;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] deadline;
      logic [31:0] period;
      logic        rep;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

endpackage

[design/otimer_ram.sv]
module otimer_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[design/ordered_timer_table.sv]
// Flow: cancel, unknown codes and a poll of an empty table answer from the start state;
//   refresh reads and rewrites its slot; query, add with a free slot and a poll with nothing
//   due scan every slot; reset reads its slot and scans if it changes it. A poll that emits
//   scans once to mark the due slots, then once for each slot that it gives.
// Throughput: one operation at a time, set by the single read port of the
//   slot memory that every scan walks one slot per cycle.
// Reset: synchronous, clears the active bits, time and notify flag, loads the default window.
module ordered_timer_table #(
   parameter int NUM_SLOTS = otimer_pkg::NUM_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  otimer_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output otimer_pkg::rsp_type rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_wdata
);
   import otimer_pkg::*;

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_RDW   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]           state_ff, state_in;
   req_type              req_ff, req_in;
   logic [31:0]          window_ff, window_in;
   logic [63:0]          prev_ff, prev_in;
   logic                 notify_ff, notify_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] due_ff, due_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 arr_vld_ff, arr_vld_in;
   logic [IW-1:0]        arr_idx_ff, arr_idx_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   entry_type            best_ff, best_in;
   logic [IW-1:0]        tgt_idx_ff, tgt_idx_in;
   entry_type            tgt_ff, tgt_in;
   logic                 roll_ff, roll_in;
   logic                 scan_due_ff, scan_due_in;
   logic [4:0]           emit_ff, emit_in;
   logic                 cont_ff, cont_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   entry_type     ram_wdata;
   logic [IW-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata_raw;
   entry_type     ram_rdata;

   logic          sid_ok;
   logic [IW-1:0] sidx;
   logic          act_s;
   logic          free_found;
   logic [IW-1:0] free_idx;
   logic [63:0]   start_t;
   logic          cand;
   logic          front;
   logic          last_emit;
   logic [NUM_SLOTS-1:0] due_rest;

   otimer_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata_raw)
   );

   assign ram_rdata   = entry_type'(ram_rdata_raw);
   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sid_ok = (int'(req_ff.slot_id) < NUM_SLOTS);
   assign sidx   = IW'(req_ff.slot_id);
   assign act_s  = sid_ok && active_ff[sidx];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      window_in    = window_ff;
      prev_in      = prev_ff;
      notify_in    = notify_ff;
      active_in    = active_ff;
      due_in       = due_ff;
      cnt_in       = cnt_ff;
      arr_vld_in   = 1'b0;
      arr_idx_in   = arr_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      tgt_idx_in   = tgt_idx_ff;
      tgt_in       = tgt_ff;
      roll_in      = roll_ff;
      scan_due_in  = scan_due_ff;
      emit_in      = emit_ff;
      cont_in      = cont_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = tgt_idx_ff;
      ram_wdata    = tgt_ff;
      ram_raddr    = (state_ff == S_SCAN) ? cnt_ff[IW-1:0] : sidx;
      start_t      = '0;
      cand         = 1'b0;
      front        = 1'b0;
      last_emit    = 1'b0;
      due_rest     = due_ff;

      if (csr_valid) begin
         window_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      res_in.result_slot  = res_ff.result_slot;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_START;
            end
         end
         S_START: begin
            res_in      = '0;
            res_in.last = 1'b1;
            cont_in     = 1'b0;
            cnt_in      = '0;
            found_in    = 1'b0;
            scan_due_in = 1'b0;
            emit_in     = '0;
            state_in    = S_RESP;
            priority case (req_ff.operation)
               OP_ADD: begin
                  if (!free_found) begin
                     res_in.status = ST_FULL;
                  end else begin
                     tgt_idx_in      = free_idx;
                     tgt_in.deadline = sat_add(req_ff.now_ms, {32'b0, req_ff.period_ms});
                     tgt_in.period   = req_ff.period_ms;
                     tgt_in.rep      = req_ff.repeat_mode;
                     state_in        = S_SCAN;
                  end
               end
               OP_CANCEL: begin
                  if (!act_s) begin
                     res_in.status = ST_INACTIVE;
                  end else begin
                     active_in[sidx] = 1'b0;
                  end
               end
               OP_REFRESH, OP_RESET: begin
                  if (!sid_ok || (req_ff.operation == OP_REFRESH && !act_s)) begin
                     res_in.status = ST_INACTIVE;
                  end else begin
                     tgt_idx_in = sidx;
                     state_in   = S_RDW;
                  end
               end
               OP_POLL: begin
                  if (active_ff == '0) begin
                     res_in.status = ST_NONE_DUE;
                  end else begin
                     roll_in     = (req_ff.now_ms < prev_ff) &&
                                   ((prev_ff - req_ff.now_ms) > {32'b0, window_ff});
                     prev_in     = req_ff.now_ms;
                     scan_due_in = 1'b1;
                     state_in    = S_SCAN;
                  end
               end
               OP_QUERY: begin
                  notify_in = 1'b0;
                  state_in  = S_SCAN;
               end
               default: begin
               end
            endcase
         end
         S_RDW: begin
            state_in = S_RESP;
            if (req_ff.operation == OP_REFRESH) begin
               ram_we             = 1'b1;
               ram_wdata          = ram_rdata;
               ram_wdata.deadline = sat_add(req_ff.now_ms, {32'b0, ram_rdata.period});
            end else if (req_ff.period_ms == ram_rdata.period && !req_ff.restart_now) begin
               res_in.status = ST_OK;
            end else if (!act_s) begin
               res_in.status = ST_INACTIVE;
            end else begin
               if (req_ff.restart_now) begin
                  start_t = req_ff.now_ms;
               end else if (ram_rdata.deadline >= {32'b0, ram_rdata.period}) begin
                  start_t = ram_rdata.deadline - {32'b0, ram_rdata.period};
               end
               tgt_in.deadline = sat_add(start_t, {32'b0, req_ff.period_ms});
               tgt_in.period   = req_ff.period_ms;
               tgt_in.rep      = ram_rdata.rep;
               state_in        = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff != CW'(NUM_SLOTS)) begin
               arr_vld_in = 1'b1;
               arr_idx_in = cnt_ff[IW-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (arr_vld_ff) begin
               if (scan_due_ff) begin
                  due_in[arr_idx_ff] = active_ff[arr_idx_ff] &&
                                       (roll_ff || ram_rdata.deadline <= req_ff.now_ms);
               end else begin
                  priority case (req_ff.operation)
                     OP_POLL: cand = due_ff[arr_idx_ff];
                     OP_ADD, OP_RESET: cand = active_ff[arr_idx_ff] &&
                                              (arr_idx_ff != tgt_idx_ff);
                     default: cand = active_ff[arr_idx_ff];
                  endcase
                  if (cand && (!found_ff || ram_rdata.deadline < best_ff.deadline)) begin
                     found_in    = 1'b1;
                     best_idx_in = arr_idx_ff;
                     best_in     = ram_rdata;
                  end
               end
            end else if (cnt_ff == CW'(NUM_SLOTS)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_RESP;
            priority case (req_ff.operation)
               OP_ADD, OP_RESET: begin
                  front = (!found_ff || tgt_ff.deadline < best_ff.deadline ||
                           (tgt_ff.deadline == best_ff.deadline && tgt_idx_ff < best_idx_ff))
                          && !notify_ff;
                  if (front) begin
                     notify_in = 1'b1;
                  end
                  res_in.front_notify = front;
                  if (req_ff.operation == OP_ADD) begin
                     res_in.result_slot    = 4'(tgt_idx_ff);
                     active_in[tgt_idx_ff] = 1'b1;
                  end
                  ram_we = 1'b1;
               end
               OP_POLL: begin
                  if (scan_due_ff) begin
                     if (due_ff == '0) begin
                        res_in.status = ST_NONE_DUE;
                     end else begin
                        scan_due_in = 1'b0;
                        cnt_in      = '0;
                        found_in    = 1'b0;
                        state_in    = S_SCAN;
                     end
                  end else begin
                     due_rest[best_idx_ff] = 1'b0;
                     last_emit             = (emit_ff == 5'(MAX_RESULTS - 1)) ||
                                             (due_rest == '0);
                     due_in                = due_rest;
                     emit_in               = emit_ff + 1'b1;
                     res_in.result_slot    = 4'(best_idx_ff);
                     res_in.last           = last_emit;
                     cont_in               = !last_emit;
                     ram_waddr             = best_idx_ff;
                     ram_wdata             = best_ff;
                     ram_wdata.deadline    = sat_add(req_ff.now_ms, {32'b0, best_ff.period});
                     if (best_ff.rep) begin
                        ram_we = 1'b1;
                     end else begin
                        active_in[best_idx_ff] = 1'b0;
                     end
                  end
               end
               default: begin
                  if (!found_ff) begin
                     res_in.delay_ms = '1;
                  end else if (req_ff.now_ms >= best_ff.deadline) begin
                     res_in.delay_ms = '0;
                  end else begin
                     res_in.delay_ms = best_ff.deadline - req_ff.now_ms;
                  end
               end
            endcase
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               if (cont_ff) begin
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_RESET;
         prev_ff      <= '0;
         notify_ff    <= 1'b0;
         active_ff    <= '0;
         arr_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cont_ff      <= 1'b0;
         scan_due_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         prev_ff      <= prev_in;
         notify_ff    <= notify_in;
         active_ff    <= active_in;
         arr_vld_ff   <= arr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         cont_ff      <= cont_in;
         scan_due_ff  <= scan_due_in;
      end
      req_ff      <= req_in;
      due_ff      <= due_in;
      cnt_ff      <= cnt_in;
      arr_idx_ff  <= arr_idx_in;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      tgt_idx_ff  <= tgt_idx_in;
      tgt_ff      <= tgt_in;
      roll_ff     <= roll_in;
      emit_ff     <= emit_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

endmodule

[verif/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import otimer_pkg::*;

   localparam int SLOTS = 16;
   localparam int STALL_LIMIT = 20000;

   class timer_scoreboard;
      bit          active [SLOTS];
      bit [63:0]   deadline [SLOTS];
      bit [31:0]   period [SLOTS];
      bit          rep [SLOTS];
      bit [63:0]   prev_time;
      bit          notify_pending;
      bit [31:0]   window;
      rsp_type     pending_rsp [$];
      int          errors;
      int          rsp_count;
      int          expired_count;

      function void clear_state();
         for (int i = 0; i < SLOTS; i++) begin
            active[i] = 0;
            deadline[i] = 0;
            period[i] = 0;
            rep[i] = 0;
         end
         prev_time = 0;
         notify_pending = 0;
         window = WINDOW_RESET;
      endfunction

      function bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
         bit [64:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[64] ? '1 : s[63:0];
      endfunction

      function bit orders_first(int a, int b);
         if (deadline[a] != deadline[b]) return deadline[a] < deadline[b];
         return a < b;
      endfunction

      function int earliest_slot();
         int best;
         best = -1;
         for (int i = 0; i < SLOTS; i++)
            if (active[i] && (best < 0 || orders_first(i, best))) best = i;
         return best;
      endfunction

      function bit front_check(int s);
         bit is_first;
         is_first = (earliest_slot() == s) && !notify_pending;
         if (is_first) notify_pending = 1;
         return is_first;
      endfunction

      function void push(bit [1:0] st, bit [3:0] sl, bit [63:0] d, bit fn, bit lst);
         rsp_type r;
         r.status = st;
         r.result_slot = sl;
         r.delay_ms = d;
         r.front_notify = fn;
         r.last = lst;
         pending_rsp = {pending_rsp, r};
      endfunction

      function int active_count();
         int n;
         n = 0;
         for (int i = 0; i < SLOTS; i++) n += active[i];
         return n;
      endfunction

      function void note_request(req_type q);
         int s, f, first, n, b;
         bit roll;
         bit due [SLOTS];
         int order [$];
         bit [63:0] start, d;
         s = q.slot_id;
         case (q.operation)
            OP_ADD: begin
               f = -1;
               for (int i = 0; i < SLOTS && f < 0; i++)
                  if (!active[i]) f = i;
               if (f < 0) push(ST_FULL, 0, 0, 0, 1);
               else begin
                  active[f] = 1;
                  period[f] = q.period_ms;
                  rep[f] = q.repeat_mode;
                  deadline[f] = add_sat(q.now_ms, {32'd0, q.period_ms});
                  push(ST_OK, 4'(f), 0, front_check(f), 1);
               end
            end
            OP_CANCEL: begin
               if (!active[s]) push(ST_INACTIVE, 0, 0, 0, 1);
               else begin
                  active[s] = 0;
                  push(ST_OK, 0, 0, 0, 1);
               end
            end
            OP_REFRESH: begin
               if (!active[s]) push(ST_INACTIVE, 0, 0, 0, 1);
               else begin
                  deadline[s] = add_sat(q.now_ms, {32'd0, period[s]});
                  push(ST_OK, 0, 0, 0, 1);
               end
            end
            OP_RESET: begin
               if (q.period_ms == period[s] && !q.restart_now) push(ST_OK, 0, 0, 0, 1);
               else if (!active[s]) push(ST_INACTIVE, 0, 0, 0, 1);
               else begin
                  if (q.restart_now) start = q.now_ms;
                  else if (deadline[s] >= {32'd0, period[s]})
                     start = deadline[s] - {32'd0, period[s]};
                  else start = 0;
                  period[s] = q.period_ms;
                  deadline[s] = add_sat(start, {32'd0, q.period_ms});
                  push(ST_OK, 0, 0, front_check(s), 1);
               end
            end
            OP_POLL: begin
               first = earliest_slot();
               if (first < 0) push(ST_NONE_DUE, 0, 0, 0, 1);
               else begin
                  roll = q.now_ms < prev_time && (prev_time - q.now_ms) > {32'd0, window};
                  prev_time = q.now_ms;
                  if (!roll && deadline[first] > q.now_ms) push(ST_NONE_DUE, 0, 0, 0, 1);
                  else begin
                     for (int i = 0; i < SLOTS; i++)
                        due[i] = active[i] && (roll || deadline[i] <= q.now_ms);
                     n = 0;
                     while (n < MAX_RESULTS) begin
                        b = -1;
                        for (int i = 0; i < SLOTS; i++)
                           if (due[i] && (b < 0 || orders_first(i, b))) b = i;
                        if (b < 0) break;
                        due[b] = 0;
                        order = {order, b};
                        n++;
                     end
                     foreach (order[k]) begin
                        push(ST_OK, 4'(order[k]), 0, 0, k == order.size() - 1);
                        if (rep[order[k]])
                           deadline[order[k]] = add_sat(q.now_ms, {32'd0, period[order[k]]});
                        else active[order[k]] = 0;
                     end
                     expired_count += n;
                  end
               end
            end
            OP_QUERY: begin
               notify_pending = 0;
               first = earliest_slot();
               if (first < 0) d = '1;
               else if (q.now_ms >= deadline[first]) d = 0;
               else d = deadline[first] - q.now_ms;
               push(ST_OK, 0, d, 0, 1);
            end
            default: push(ST_OK, 0, 0, 0, 1);
         endcase
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %p", a);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
         end
         if (a.result_slot !== e.result_slot) begin
            $error("result_slot exp %0d got %0d", e.result_slot, a.result_slot); errors++;
         end
         if (a.delay_ms !== e.delay_ms) begin
            $error("delay_ms exp %0h got %0h", e.delay_ms, a.delay_ms); errors++;
         end
         if (a.front_notify !== e.front_notify) begin
            $error("front_notify exp %0d got %0d", e.front_notify, a.front_notify); errors++;
         end
         if (a.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, a.last); errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_payload;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [31:0] csr_wdata = '0;

   timer_scoreboard timers;
   bit [63:0] clock_ms;
   bit        written [SLOTS];
   bit        long_hold;
   int        idle_cycles;
   int        req_count;

   ordered_timer_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) timers.note_request(req_payload);
         if (rsp_valid && rsp_ready) timers.check_response(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send(req_type q, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      if (q.operation == OP_RESET && !q.restart_now && !written[q.slot_id])
         q.restart_now = 1;
      if (q.operation == OP_ADD && timers.active_count() < SLOTS)
         for (int i = 0; i < SLOTS; i++)
            if (!timers.active[i]) begin
               written[i] = 1;
               break;
            end
      req_valid <= 1;
      req_payload <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (timers.pending_rsp.size() != 0) @(negedge clock);
      repeat (SLOTS * 20) @(negedge clock);
   endtask

   task automatic write_window(bit [31:0] w);
      wait_drained();
      csr_valid <= 1;
      csr_wdata <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      timers.window = w;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic req_type make_req(bit [2:0] op, bit [63:0] now, bit [3:0] sid,
                                        bit [31:0] per, bit rp, bit fn);
      req_type q;
      q.operation = op;
      q.now_ms = now;
      q.slot_id = sid;
      q.period_ms = per;
      q.repeat_mode = rp;
      q.restart_now = fn;
      return q;
   endfunction

   function automatic req_type random_req();
      bit [2:0] op;
      bit [31:0] per;
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_ADD;
      else if (r < 40) op = OP_CANCEL;
      else if (r < 48) op = OP_REFRESH;
      else if (r < 60) op = OP_RESET;
      else if (r < 85) op = OP_POLL;
      else if (r < 97) op = OP_QUERY;
      else op = 3'($urandom_range(6, 7));
      r = $urandom_range(0, 19);
      if (r == 0) clock_ms = {$urandom, $urandom};
      else if (r == 1) clock_ms = clock_ms - 64'($urandom_range(0, 8000000));
      else if (r == 2) clock_ms = '1 - 64'($urandom_range(0, 100));
      else clock_ms = clock_ms + 64'($urandom_range(0, 300));
      r = $urandom_range(0, 9);
      per = r == 0 ? $urandom : (r == 1 ? 32'hFFFFFFFF : $urandom_range(0, 400));
      return make_req(op, clock_ms, 4'($urandom_range(0, 15)), per,
                      1'($urandom), 1'($urandom));
   endfunction

   initial begin
      timers = new();
      timers.clear_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send(make_req(OP_POLL, 64'd5, 0, 0, 0, 0), 0);
      send(make_req(OP_QUERY, 64'd5, 0, 0, 0, 0), 0);
      send(make_req(OP_CANCEL, 64'd5, 4'd15, 0, 0, 0), 0);
      send(make_req(OP_REFRESH, 64'd5, 4'd3, 0, 0, 0), 0);
      send(make_req(OP_ADD, 64'd100, 0, 32'd50, 1, 0), 0);
      send(make_req(OP_ADD, 64'd100, 0, 32'd50, 0, 0), 0);
      send(make_req(OP_ADD, '1, 0, 32'hFFFFFFFF, 1, 1), 0);
      send(make_req(OP_ADD, 64'd0, 0, 32'd0, 0, 1), 0);
      send(make_req(OP_QUERY, 64'd10, 0, 0, 0, 0), 0);
      send(make_req(OP_RESET, 64'd20, 4'd1, 32'd50, 0, 0), 0);
      send(make_req(OP_RESET, 64'd20, 4'd1, 32'd10, 0, 0), 0);
      send(make_req(OP_RESET, 64'd20, 4'd0, 32'd5, 0, 1), 0);
      send(make_req(OP_RESET, 64'd20, 4'd9, 32'd7, 0, 1), 0);
      send(make_req(OP_REFRESH, 64'd30, 4'd3, 0, 0, 0), 0);
      send(make_req(OP_POLL, 64'd160, 0, 0, 0, 0), 0);
      send(make_req(OP_ADD, 64'd160, 0, 32'd1, 0, 0), 0);
      send(make_req(OP_POLL, 64'd5000000, 0, 0, 0, 0), 0);
      send(make_req(OP_POLL, 64'd100, 0, 0, 0, 0), 0);
      send(make_req(3'd6, 64'd100, 0, 0, 0, 0), 0);
      send(make_req(3'd7, '1, 4'd15, '1, 1, 1), 0);
      send(make_req(OP_CANCEL, 64'd100, 4'd2, 0, 0, 0), 0);
      for (int i = 0; i < 17; i++)
         send(make_req(OP_ADD, 64'd200, 0, 32'd10, i[0], 0), 1);
      send(make_req(OP_POLL, 64'd300, 0, 0, 0, 0), 0);

      clock_ms = 1000;
      write_window('1);
      write_window(32'd0);
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 1) write_window(32'd1000);
         if (phase == 2) write_window(WINDOW_RESET);
         if (phase == 3) write_window(32'hFFFFFFFF);
         if (phase == 1) long_hold = 1;
         for (int k = 0; k < 100; k++) begin
            send(random_req(), phase == 1 && k < 40);
            if (phase == 2 && k == 50) wait_drained();
         end
      end

      wait_drained();
      $display("Covered %0d requests, %0d responses, %0d expiries, window writes at extremes.",
               req_count, timers.rsp_count, timers.expired_count);
      if (timers.errors == 0 && timers.pending_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
